[hw/rtl/krps_pkg.sv]
package krps_pkg;

  localparam int IMG_FRAC   = 20;
  localparam int PT_W       = 24;
  localparam int CRD_W      = 32;
  localparam int MIN_SEP_W  = 41;
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_PAD_LSB = 146;
  localparam int RES_W      = 48;

  // input queue between front and back
  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // datapath widths, sized from the operand ranges
  localparam int BX_W      = 57;   // x*2^f - u*z and sums of two
  localparam int SU_W      = 25;   // u1+u2, u1-u2
  localparam int ACC_W     = 84;   // R, N, cz
  localparam int DSQ_W     = 51;   // D
  localparam int WIDE_W    = 112;  // cz*Su - Bx
  localparam int MA_W      = 97;
  localparam int MB_W      = 26;
  localparam int PROD_W    = 128;
  localparam int DIV_NUM_W = 84;
  localparam int DIV_DEN_W = 50;

  typedef struct packed {
    logic                    est;
    logic signed [PT_W-1:0]  u_first;
    logic signed [PT_W-1:0]  v_first;
    logic signed [CRD_W-1:0] x_first;
    logic signed [CRD_W-1:0] y_first;
    logic signed [CRD_W-1:0] z_first;
    logic signed [PT_W-1:0]  u_second;
    logic signed [PT_W-1:0]  v_second;
    logic signed [CRD_W-1:0] x_second;
    logic signed [CRD_W-1:0] y_second;
    logic signed [CRD_W-1:0] z_second;
  } krps_item_t;

endpackage

[hw/rtl/krps_front.sv]
module krps_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [krps_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            q_pop,
  output logic                            q_valid,
  output krps_pkg::krps_item_t            q_item
);
  import krps_pkg::*;

  krps_item_t            item;
  krps_item_t            mem_r [QDEPTH];
  logic [QP_W-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]       cnt_r, cnt_nxt;
  logic                  push, pop;

  // cmd 0 is an estimate, cmd 1 a residual check
  always_comb begin
    item.est      = ~in_tuser;
    item.u_first  = in_tdata[23:0];
    item.v_first  = in_tdata[47:24];
    item.x_first  = in_tdata[79:48];
    item.y_first  = in_tdata[111:80];
    item.z_first  = in_tdata[143:112];
    item.u_second = in_tdata[167:144];
    item.v_second = in_tdata[191:168];
    item.x_second = in_tdata[223:192];
    item.y_second = in_tdata[255:224];
    item.z_second = in_tdata[287:256];
  end

  assign in_tready = (cnt_r != QC_W'(QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QC_W'(push) - QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

[hw/rtl/krps_mul.sv]
module krps_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [krps_pkg::MA_W-1:0]    a,
  input  logic signed [krps_pkg::MB_W-1:0]    b,
  output logic                                done,
  output logic signed [krps_pkg::PROD_W-1:0]  prod
);
  import krps_pkg::*;

  localparam int CH_W  = 32;
  localparam int CH_N  = (MA_W - 1) / CH_W;
  localparam int AM_W  = CH_N * CH_W;
  localparam int BM_W  = MB_W - 1;
  localparam int PP_W  = CH_W + BM_W;
  localparam int CNT_W = $clog2(CH_N + 1);

  logic [AM_W-1:0]   am_r, am_nxt;
  logic [BM_W-1:0]   bm_r, bm_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [MA_W-1:0]   a_abs;
  logic [MB_W-1:0]   b_abs;
  logic [PP_W-1:0]   pp;

  assign a_abs = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
  assign b_abs = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
  // top chunk first, so the accumulator only ever shifts by a fixed amount
  assign pp    = PP_W'(am_r[AM_W-1 -: CH_W]) * PP_W'(bm_r);

  always_comb begin
    am_nxt   = am_r;
    bm_nxt   = bm_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      am_nxt  = a_abs[AM_W-1:0];
      bm_nxt  = b_abs[BM_W-1:0];
      neg_nxt = a[MA_W-1] ^ b[MB_W-1];
      acc_nxt = '0;
      cnt_nxt = CNT_W'(CH_N);
    end else if (cnt_r != '0) begin
      acc_nxt  = (acc_r << CH_W) + PROD_W'(pp);
      am_nxt   = am_r << CH_W;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    am_r  <= am_nxt;
    bm_r  <= bm_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? -signed'(acc_r) : signed'(acc_r);

endmodule

[hw/rtl/krps_div.sv]
module krps_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [krps_pkg::DIV_NUM_W-1:0]    num,
  input  logic [krps_pkg::DIV_DEN_W-1:0]    den,
  output logic                              done,
  output logic [krps_pkg::DIV_NUM_W-1:0]    quo
);
  import krps_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial, diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle; numerator shifts out
  // of the top of quo_r while quotient bits shift in at the bottom
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      den_nxt = den;
      quo_nxt = num;
      cnt_nxt = CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_nxt  = {quo_r[DIV_NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hw/rtl/krps_back.sv]
module krps_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [krps_pkg::MIN_SEP_W-1:0]   cfg_wr_data,
  input  logic                             q_valid,
  output logic                             q_pop,
  input  krps_pkg::krps_item_t             q_item,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [krps_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import krps_pkg::*;

  localparam int PW   = CRD_W + 1;   // point plus held position
  localparam int QW   = 53;          // projected coordinate magnitude
  localparam int EW   = 55;          // image error before range check
  localparam int RS_W = RES_W + 1;
  localparam logic [RS_W-1:0] RES_SAT = {1'b0, {RES_W{1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-CRD_W+1){1'b0}}, {(CRD_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-CRD_W+1){1'b1}}, {(CRD_W-1){1'b0}}};

  typedef enum logic [7:0] {
    B_IDLE = 8'b0000_0001,
    B_MUL  = 8'b0000_0010,
    B_DIV  = 8'b0000_0100,
    B_CHK  = 8'b0000_1000,
    B_ERR  = 8'b0001_0000,
    B_RES  = 8'b0010_0000,
    B_FIN  = 8'b0100_0000,
    B_OUT  = 8'b1000_0000
  } bstate_t;

  typedef enum logic [3:0] {
    S_UZ1, S_VZ1, S_UZ2, S_VZ2, S_UB1, S_VB1, S_UB2, S_VB2,
    S_SUBX, S_SVBY, S_DU, S_DV, S_CZU, S_CZV, S_EU, S_EV
  } mstep_t;

  typedef enum logic [1:0] {D_CZ, D_PU, D_PV} dsel_t;

  typedef struct packed {
    logic                    sat;
    logic signed [CRD_W-1:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[CRD_W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[CRD_W-1:0]};
    end else begin
      r = {1'b0, v[CRD_W-1:0]};
    end
    return r;
  endfunction

  // divide by 2^(f+1), round half away from zero
  function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0] m;
    m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    m = (m + (WIDE_W'(1) << IMG_FRAC)) >> (IMG_FRAC + 1);
    return v[WIDE_W-1] ? -signed'(m) : signed'(m);
  endfunction

  bstate_t                   state_r, state_nxt;
  mstep_t                    step_r, step_nxt;
  dsel_t                     dsel_r, dsel_nxt;
  logic                      mul_go_r, mul_go_nxt, div_go_r, div_go_nxt;
  krps_item_t                it_r, it_nxt;
  logic signed [BX_W-1:0]    bx1_r, bx1_nxt, by1_r, by1_nxt, bx2_r, bx2_nxt, by2_r, by2_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, cz_r, cz_nxt;
  logic [DSQ_W-1:0]          dsq_r, dsq_nxt;
  logic signed [WIDE_W-1:0]  cxr_r, cxr_nxt, cyr_r, cyr_nxt;
  logic signed [PW-1:0]      px_r, px_nxt, py_r, py_nxt, w_r, w_nxt;
  logic [QW-1:0]             qu_r, qu_nxt, qv_r, qv_nxt;
  logic [PT_W-1:0]           eu_r, eu_nxt, ev_r, ev_nxt;
  logic [RS_W-1:0]           res_r, res_nxt;
  logic signed [CRD_W-1:0]   hx_r, hx_nxt, hy_r, hy_nxt, hz_r, hz_nxt;
  logic                      hvalid_r, hvalid_nxt;
  logic                      solved_r, solved_nxt, fault_r, fault_nxt;
  logic [MIN_SEP_W-1:0]      minsep_r;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic                      mul_done;
  logic signed [PROD_W-1:0]  mul_prod;
  logic [DIV_NUM_W-1:0]      div_num, div_quo;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_done;

  logic signed [BX_W-1:0]    bxs, bys;
  logic signed [SU_W-1:0]    su, sv, du, dv;
  logic [ACC_W-1:0]          acc_abs;
  logic [PW-1:0]             px_mag, py_mag;
  logic signed [PW-1:0]      rpx, rpy, rw;
  logic signed [EW-1:0]      pu, pv, eu_full, ev_full;
  logic [EW-1:0]             eu_abs, ev_abs;
  logic                      eu_big, ev_big;
  sat_t                      sx, sy, sz;

  krps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  krps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign bxs = bx1_r + bx2_r;
  assign bys = by1_r + by2_r;
  assign su  = SU_W'(it_r.u_first) + SU_W'(it_r.u_second);
  assign sv  = SU_W'(it_r.v_first) + SU_W'(it_r.v_second);
  assign du  = SU_W'(it_r.u_first) - SU_W'(it_r.u_second);
  assign dv  = SU_W'(it_r.v_first) - SU_W'(it_r.v_second);

  always_comb begin
    unique case (step_r)
      S_UZ1:   begin mul_a = MA_W'(it_r.z_first);  mul_b = MB_W'(it_r.u_first);  end
      S_VZ1:   begin mul_a = MA_W'(it_r.z_first);  mul_b = MB_W'(it_r.v_first);  end
      S_UZ2:   begin mul_a = MA_W'(it_r.z_second); mul_b = MB_W'(it_r.u_second); end
      S_VZ2:   begin mul_a = MA_W'(it_r.z_second); mul_b = MB_W'(it_r.v_second); end
      S_UB1:   begin mul_a = MA_W'(bx1_r);         mul_b = MB_W'(it_r.u_first);  end
      S_VB1:   begin mul_a = MA_W'(by1_r);         mul_b = MB_W'(it_r.v_first);  end
      S_UB2:   begin mul_a = MA_W'(bx2_r);         mul_b = MB_W'(it_r.u_second); end
      S_VB2:   begin mul_a = MA_W'(by2_r);         mul_b = MB_W'(it_r.v_second); end
      S_SUBX:  begin mul_a = MA_W'(bxs);           mul_b = MB_W'(su);            end
      S_SVBY:  begin mul_a = MA_W'(bys);           mul_b = MB_W'(sv);            end
      S_DU:    begin mul_a = MA_W'(du);            mul_b = MB_W'(du);            end
      S_DV:    begin mul_a = MA_W'(dv);            mul_b = MB_W'(dv);            end
      S_CZU:   begin mul_a = MA_W'(cz_r);          mul_b = MB_W'(su);            end
      S_CZV:   begin mul_a = MA_W'(cz_r);          mul_b = MB_W'(sv);            end
      S_EU:    begin mul_a = MA_W'({1'b0, eu_r});  mul_b = MB_W'({1'b0, eu_r});  end
      S_EV:    begin mul_a = MA_W'({1'b0, ev_r});  mul_b = MB_W'({1'b0, ev_r});  end
      default: begin mul_a = '0;                   mul_b = '0;                   end
    endcase
  end

  // divider operands carry the half-divisor bias for rounding to nearest
  assign acc_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign px_mag  = px_r[PW-1] ? PW'(-px_r) : PW'(px_r);
  assign py_mag  = py_r[PW-1] ? PW'(-py_r) : PW'(py_r);

  always_comb begin
    unique case (dsel_r)
      D_CZ: begin
        div_num = DIV_NUM_W'(acc_abs) + DIV_NUM_W'(dsq_r >> 1);
        div_den = dsq_r[DIV_DEN_W-1:0];
      end
      D_PU: begin
        div_num = (DIV_NUM_W'(px_mag) << IMG_FRAC) + DIV_NUM_W'(w_r[PW-1:1]);
        div_den = DIV_DEN_W'(unsigned'(w_r));
      end
      default: begin
        div_num = (DIV_NUM_W'(py_mag) << IMG_FRAC) + DIV_NUM_W'(w_r[PW-1:1]);
        div_den = DIV_DEN_W'(unsigned'(w_r));
      end
    endcase
  end

  assign rpx = PW'(q_item.x_first) + PW'(hx_r);
  assign rpy = PW'(q_item.y_first) + PW'(hy_r);
  assign rw  = PW'(q_item.z_first) + PW'(hz_r);

  assign pu      = px_r[PW-1] ? -signed'(EW'(qu_r)) : signed'(EW'(qu_r));
  assign pv      = py_r[PW-1] ? -signed'(EW'(qv_r)) : signed'(EW'(qv_r));
  assign eu_full = EW'(it_r.u_first) - pu;
  assign ev_full = EW'(it_r.v_first) - pv;
  assign eu_abs  = eu_full[EW-1] ? EW'(-eu_full) : EW'(eu_full);
  assign ev_abs  = ev_full[EW-1] ? EW'(-ev_full) : EW'(ev_full);
  assign eu_big  = |eu_abs[EW-1:PT_W];
  assign ev_big  = |ev_abs[EW-1:PT_W];

  assign sx = sat32(rnd_shr(cxr_r));
  assign sy = sat32(rnd_shr(cyr_r));
  assign sz = sat32(WIDE_W'(cz_r));

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    dsel_nxt    = dsel_r;
    mul_go_nxt  = 1'b0;
    div_go_nxt  = 1'b0;
    it_nxt      = it_r;
    bx1_nxt     = bx1_r;
    by1_nxt     = by1_r;
    bx2_nxt     = bx2_r;
    by2_nxt     = by2_r;
    acc_nxt     = acc_r;
    cz_nxt      = cz_r;
    dsq_nxt     = dsq_r;
    cxr_nxt     = cxr_r;
    cyr_nxt     = cyr_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    w_nxt       = w_r;
    qu_nxt      = qu_r;
    qv_nxt      = qv_r;
    eu_nxt      = eu_r;
    ev_nxt      = ev_r;
    res_nxt     = res_r;
    hx_nxt      = hx_r;
    hy_nxt      = hy_r;
    hz_nxt      = hz_r;
    hvalid_nxt  = hvalid_r;
    solved_nxt  = solved_r;
    fault_nxt   = fault_r;
    q_pop       = 1'b0;
    out_data_nxt = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          it_nxt     = q_item;
          fault_nxt  = 1'b0;
          res_nxt    = '0;
          solved_nxt = 1'b0;
          if (q_item.est) begin
            step_nxt   = S_UZ1;
            mul_go_nxt = 1'b1;
            state_nxt  = B_MUL;
          end else begin
            px_nxt     = rpx;
            py_nxt     = rpy;
            w_nxt      = rw;
            solved_nxt = hvalid_r;
            if (rw <= 0) begin
              fault_nxt = 1'b1;
              res_nxt   = RES_SAT;
              state_nxt = B_OUT;
            end else begin
              dsel_nxt   = D_PU;
              div_go_nxt = 1'b1;
              state_nxt  = B_DIV;
            end
          end
        end
      end
      B_MUL: begin
        if (mul_done) begin
          unique case (step_r)
            S_UZ1:  bx1_nxt = (BX_W'(it_r.x_first) <<< IMG_FRAC) - BX_W'(mul_prod);
            S_VZ1:  by1_nxt = (BX_W'(it_r.y_first) <<< IMG_FRAC) - BX_W'(mul_prod);
            S_UZ2:  bx2_nxt = (BX_W'(it_r.x_second) <<< IMG_FRAC) - BX_W'(mul_prod);
            S_VZ2:  by2_nxt = (BX_W'(it_r.y_second) <<< IMG_FRAC) - BX_W'(mul_prod);
            S_UB1:  acc_nxt = ACC_W'(mul_prod);
            S_VB1:  acc_nxt = acc_r + ACC_W'(mul_prod);
            S_UB2:  acc_nxt = acc_r + ACC_W'(mul_prod);
            S_VB2:  acc_nxt = acc_r + ACC_W'(mul_prod);
            S_SUBX: acc_nxt = (acc_r <<< 1) - ACC_W'(mul_prod);
            S_SVBY: acc_nxt = acc_r - ACC_W'(mul_prod);
            S_DU:   dsq_nxt = DSQ_W'(mul_prod);
            S_DV:   dsq_nxt = dsq_r + DSQ_W'(mul_prod);
            S_CZU:  cxr_nxt = WIDE_W'(mul_prod) - WIDE_W'(bxs);
            S_CZV:  cyr_nxt = WIDE_W'(mul_prod) - WIDE_W'(bys);
            S_EU:   res_nxt = RS_W'(mul_prod);
            S_EV:   res_nxt = res_r + RS_W'(mul_prod);
            default: ;
          endcase
          priority if (step_r == S_DV) begin
            state_nxt = B_CHK;
          end else if (step_r == S_CZV) begin
            state_nxt = B_FIN;
          end else if (step_r == S_EV) begin
            state_nxt = B_RES;
          end else begin
            step_nxt   = mstep_t'(step_r + 4'd1);
            mul_go_nxt = 1'b1;
          end
        end
      end
      B_CHK: begin
        // too little separation between the image points: reject
        if (dsq_r == '0 || dsq_r < DSQ_W'(minsep_r)) begin
          state_nxt = B_OUT;
        end else begin
          dsel_nxt   = D_CZ;
          div_go_nxt = 1'b1;
          state_nxt  = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          unique case (dsel_r)
            D_CZ: begin
              cz_nxt     = acc_r[ACC_W-1] ? -signed'(div_quo) : signed'(div_quo);
              step_nxt   = S_CZU;
              mul_go_nxt = 1'b1;
              state_nxt  = B_MUL;
            end
            D_PU: begin
              qu_nxt     = div_quo[QW-1:0];
              dsel_nxt   = D_PV;
              div_go_nxt = 1'b1;
            end
            D_PV: begin
              qv_nxt    = div_quo[QW-1:0];
              state_nxt = B_ERR;
            end
            default: state_nxt = B_OUT;
          endcase
        end
      end
      B_ERR: begin
        if (eu_big || ev_big) begin
          fault_nxt = 1'b1;
          res_nxt   = RES_SAT;
          state_nxt = B_OUT;
        end else begin
          eu_nxt     = eu_abs[PT_W-1:0];
          ev_nxt     = ev_abs[PT_W-1:0];
          step_nxt   = S_EU;
          mul_go_nxt = 1'b1;
          state_nxt  = B_MUL;
        end
      end
      B_RES: begin
        if (res_r[RES_W]) begin
          fault_nxt = 1'b1;
          res_nxt   = RES_SAT;
        end
        state_nxt = B_OUT;
      end
      B_FIN: begin
        hx_nxt     = sx.val;
        hy_nxt     = sy.val;
        hz_nxt     = sz.val;
        hvalid_nxt = 1'b1;
        solved_nxt = 1'b1;
        fault_nxt  = sx.sat | sy.sat | sz.sat;
        state_nxt  = B_OUT;
      end
      B_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_data_nxt   = {{(OUT_DATA_W-OUT_PAD_LSB){1'b0}}, fault_r, res_r[RES_W-1:0],
                            solved_r, hz_r, hy_r, hx_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      mul_go_r     <= 1'b0;
      div_go_r     <= 1'b0;
      hx_r         <= '0;
      hy_r         <= '0;
      hz_r         <= '0;
      hvalid_r     <= 1'b0;
      minsep_r     <= MIN_SEP_W'(1);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mul_go_r     <= mul_go_nxt;
      div_go_r     <= div_go_nxt;
      hx_r         <= hx_nxt;
      hy_r         <= hy_nxt;
      hz_r         <= hz_nxt;
      hvalid_r     <= hvalid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        minsep_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    dsel_r     <= dsel_nxt;
    it_r       <= it_nxt;
    bx1_r      <= bx1_nxt;
    by1_r      <= by1_nxt;
    bx2_r      <= bx2_nxt;
    by2_r      <= by2_nxt;
    acc_r      <= acc_nxt;
    cz_r       <= cz_nxt;
    dsq_r      <= dsq_nxt;
    cxr_r      <= cxr_nxt;
    cyr_r      <= cyr_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    w_r        <= w_nxt;
    qu_r       <= qu_nxt;
    qv_r       <= qv_nxt;
    eu_r       <= eu_nxt;
    ev_r       <= ev_nxt;
    res_r      <= res_nxt;
    solved_r   <= solved_nxt;
    fault_r    <= fault_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/known_rotation_position_solver_core.sv]
// Estimate: 14 passes of the shared multiplier plus one bit-serial divide per item;
//   residual: two divides and two passes of the multiplier.
// One item is worked at a time; the shared divider sets the pace. A two-entry input
//   queue keeps accepting while the back end works, and the output register holds
//   a finished result until it is taken.
// Reset (rst_n low, synchronous): held position and valid cleared, threshold to 1.
module known_rotation_position_solver_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [krps_pkg::MIN_SEP_W-1:0]   cfg_wr_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // u_first, v_first, x_first, y_first, z_first, u_second, v_second,
  // x_second, y_second, z_second
  input  logic [krps_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pos_x, pos_y, pos_z, solved, residual_sq, fault, zero pad
  output logic [krps_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import krps_pkg::*;

  logic       q_valid;
  logic       q_pop;
  krps_item_t q_item;

  krps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  krps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

[hw/rtl/krps_checker.sv]
module krps_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [krps_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import krps_pkg::*;

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_rst_queue: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:OUT_PAD_LSB] == '0)
    else $error("result pad bits not zero");

endmodule

bind known_rotation_position_solver_core krps_checker u_krps_checker (.*);

[tb/known_rotation_position_solver_core_tb.sv]
`timescale 1ns / 1ps

module known_rotation_position_solver_core_tb;
  import krps_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               solved;
    logic [RES_W-1:0]   residual_sq;
    logic               fault;
  } solver_result_t;

  localparam logic CMD_ESTIMATE = 1'b0;
  localparam logic CMD_RESIDUAL = 1'b1;
  localparam logic [RES_W-1:0] RESIDUAL_MAX = {RES_W{1'b1}};
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [MIN_SEP_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic signed [31:0] held_x, held_y, held_z;
  logic held_ok;
  logic [MIN_SEP_W-1:0] min_sep;

  solver_result_t pending_results[$];
  int errors = 0;
  int stall_count = 0;
  bit no_idle = 1'b0;

  known_rotation_position_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic wide_t wabs(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // round to nearest, ties away from zero
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t q;
    q = (wabs(n) + (d >>> 1)) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic wide_t round_shift(wide_t v, int s);
    wide_t q;
    q = (wabs(v) + (wide_t'(1) <<< (s - 1))) >>> s;
    return v < 0 ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic solver_result_t predict_solver_step(logic cmd, krps_item_t it);
    solver_result_t r;
    wide_t u1, v1, x1, y1, z1, u2, v2, x2, y2, z2, sc;
    wide_t bx1, by1, bx2, by2, bxs, bys, su, sv, du, dv, dsq, ms, rr, num, cz;
    wide_t px, py, w, qu, qv, pu, pv, eu, ev, res;
    bit sat;
    sat = 1'b0;
    u1 = it.u_first; v1 = it.v_first; x1 = it.x_first; y1 = it.y_first; z1 = it.z_first;
    u2 = it.u_second; v2 = it.v_second; x2 = it.x_second; y2 = it.y_second;
    z2 = it.z_second;
    sc = wide_t'(1) <<< IMG_FRAC;
    ms = min_sep;
    r.solved = 1'b0;
    r.residual_sq = '0;
    if (cmd == CMD_ESTIMATE) begin
      bx1 = x1 * sc - u1 * z1; by1 = y1 * sc - v1 * z1;
      bx2 = x2 * sc - u2 * z2; by2 = y2 * sc - v2 * z2;
      bxs = bx1 + bx2; bys = by1 + by2; su = u1 + u2; sv = v1 + v2;
      du = u1 - u2; dv = v1 - v2;
      dsq = du * du + dv * dv;
      if (dsq != 0 && dsq >= ms) begin
        rr = u1 * bx1 + v1 * by1 + u2 * bx2 + v2 * by2;
        num = 2 * rr - su * bxs - sv * bys;
        cz = round_div(num, dsq);
        held_x = clamp32(round_shift(cz * su - bxs, IMG_FRAC + 1), sat);
        held_y = clamp32(round_shift(cz * sv - bys, IMG_FRAC + 1), sat);
        held_z = clamp32(cz, sat);
        held_ok = 1'b1;
        r.solved = 1'b1;
      end
    end else begin
      px = x1 + wide_t'(held_x);
      py = y1 + wide_t'(held_y);
      w = z1 + wide_t'(held_z);
      r.solved = held_ok;
      if (w <= 0) begin
        sat = 1'b1;
        r.residual_sq = RESIDUAL_MAX;
      end else begin
        qu = (wabs(px) * sc + (w >>> 1)) / w;
        qv = (wabs(py) * sc + (w >>> 1)) / w;
        pu = px < 0 ? -qu : qu;
        pv = py < 0 ? -qv : qv;
        eu = wabs(u1 - pu);
        ev = wabs(v1 - pv);
        if (eu >= (wide_t'(1) <<< 24) || ev >= (wide_t'(1) <<< 24)) begin
          sat = 1'b1;
          r.residual_sq = RESIDUAL_MAX;
        end else begin
          res = eu * eu + ev * ev;
          if (res > wide_t'(RESIDUAL_MAX)) begin
            sat = 1'b1;
            r.residual_sq = RESIDUAL_MAX;
          end else begin
            r.residual_sq = res[RES_W-1:0];
          end
        end
      end
    end
    r.pos_x = held_x;
    r.pos_y = held_y;
    r.pos_z = held_z;
    r.fault = sat;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    solver_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[63:0], 64'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[31:0] !== e.pos_x) report_mismatch("pos_x", out_tdata[31:0], e.pos_x);
        if (out_tdata[63:32] !== e.pos_y) report_mismatch("pos_y", out_tdata[63:32], e.pos_y);
        if (out_tdata[95:64] !== e.pos_z) report_mismatch("pos_z", out_tdata[95:64], e.pos_z);
        if (out_tdata[96] !== e.solved) report_mismatch("solved", out_tdata[96], e.solved);
        if (out_tdata[144:97] !== e.residual_sq)
          report_mismatch("residual_sq", out_tdata[144:97], e.residual_sq);
        if (out_tdata[145] !== e.fault) report_mismatch("fault", out_tdata[145], e.fault);
      end
    end
  end

  // result side backpressure
  initial begin
    int n;
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("known_rotation_position_solver_core regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic cmd, krps_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {it.z_second, it.y_second, it.x_second, it.v_second, it.u_second,
                 it.z_first, it.y_first, it.x_first, it.v_first, it.u_first};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_solver_step(cmd, it));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_sep(logic [MIN_SEP_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_sep = value;
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic krps_item_t noise_item();
    krps_item_t it;
    it.u_first = 24'($urandom); it.v_first = 24'($urandom);
    it.x_first = $urandom; it.y_first = $urandom; it.z_first = $urandom;
    it.u_second = 24'($urandom); it.v_second = 24'($urandom);
    it.x_second = $urandom; it.y_second = $urandom; it.z_second = $urandom;
    return it;
  endfunction

  // point seen from camera offset (cx,cy,cz) with depth in 1..64 units
  task automatic project_point(longint cx, longint cy, longint cz,
                               output logic signed [23:0] u, output logic signed [23:0] v,
                               output logic signed [31:0] x, output logic signed [31:0] y,
                               output logic signed [31:0] z);
    longint d, xx, yy;
    d = $urandom_range(1 << 16, 64 << 16);
    xx = rand_span(6 * d);
    yy = rand_span(6 * d);
    x = 32'(xx - cx); y = 32'(yy - cy); z = 32'(d - cz);
    u = 24'((xx <<< IMG_FRAC) / d + rand_span(2));
    v = 24'((yy <<< IMG_FRAC) / d + rand_span(2));
  endtask

  task automatic send_scene();
    krps_item_t it;
    longint cx, cy, cz;
    int k;
    int n_res;
    it = noise_item();
    cx = rand_span(1 << 20); cy = rand_span(1 << 20); cz = rand_span(1 << 20);
    project_point(cx, cy, cz, it.u_first, it.v_first, it.x_first, it.y_first, it.z_first);
    project_point(cx, cy, cz, it.u_second, it.v_second, it.x_second, it.y_second,
                  it.z_second);
    send_item(CMD_ESTIMATE, it);
    n_res = $urandom_range(1, 3);
    for (k = 0; k < n_res; k++) begin
      it = noise_item();
      project_point(cx, cy, cz, it.u_first, it.v_first, it.x_first, it.y_first, it.z_first);
      send_item(CMD_RESIDUAL, it);
    end
  endtask

  task automatic test_directed();
    krps_item_t it;
    it = '{default: '0};
    send_item(CMD_RESIDUAL, it);           // residual before any solve
    send_item(CMD_ESTIMATE, it);           // coincident points: rank deficient
    it.z_first = 32'sd65536;
    it.u_first = 24'sd1048576;
    send_item(CMD_RESIDUAL, it);
    it = '{default: '0};
    it.u_first = 24'sd1;                   // separation of one unit, threshold 1
    it.z_first = 32'sd65536; it.z_second = 32'sd131072;
    send_item(CMD_ESTIMATE, it);
    it = '{u_first: 24'sh7fffff, v_first: 24'sh7fffff, x_first: 32'sh7fffffff,
           y_first: 32'sh7fffffff, z_first: 32'sh7fffffff, u_second: 24'sh800000,
           v_second: 24'sh800000, x_second: 32'sh80000000, y_second: 32'sh80000000,
           z_second: 32'sh80000000, est: 1'b0};
    send_item(CMD_ESTIMATE, it);           // full-range swing, position saturates
    send_item(CMD_RESIDUAL, it);
    it.u_second = 24'sh7ffffe;             // near points, huge depths
    send_item(CMD_ESTIMATE, it);
    it = '{u_first: 24'sh800000, v_first: 24'sh800000, x_first: 32'sh80000000,
           y_first: 32'sh80000000, z_first: 32'sh80000000, u_second: 24'sh7fffff,
           v_second: 24'sh7fffff, x_second: 32'sh7fffffff, y_second: 32'sh7fffffff,
           z_second: 32'sh7fffffff, est: 1'b0};
    send_item(CMD_ESTIMATE, it);
    send_item(CMD_RESIDUAL, it);
    repeat (4) send_scene();
    it = '{default: '0};
    it.z_first = -32'sd1000000000;         // depth nonpositive
    send_item(CMD_RESIDUAL, it);
    it.z_first = 32'sh7fffffff;
    it.x_first = 32'sh7fffffff;
    it.u_first = 24'sh800000;
    send_item(CMD_RESIDUAL, it);
    it.z_first = 32'sd1;                   // projection far out of range
    it.x_first = 32'sd100000;
    send_item(CMD_RESIDUAL, it);
    drain();
  endtask

  task automatic test_random_phase(logic [MIN_SEP_W-1:0] threshold, int count);
    int sent;
    write_min_sep(threshold);
    sent = 0;
    while (sent < count) begin
      no_idle = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) < 7) begin
        send_scene();
        sent += 3;
      end else begin
        send_item(logic'($urandom_range(0, 1)), noise_item());
        sent++;
      end
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    held_x = '0; held_y = '0; held_z = '0;
    held_ok = 1'b0;
    min_sep = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(41'd0, 210);
    test_random_phase(41'h100_0000_0000, 200);
    test_random_phase(41'($urandom_range(1, 1 << 30)), 210);
    test_random_phase({1'b1, 40'($urandom)}, 200);
    test_random_phase(41'd1, 210);
    if (errors == 0) begin
      $display("known_rotation_position_solver_core regression: pass");
    end else begin
      $display("known_rotation_position_solver_core regression: fail");
    end
    $finish;
  end

endmodule
